### src/egd_pkg.sv
`timescale 1ns / 1ps
package egd_pkg;
    localparam int CARS   = 4;
    localparam int FLOORS = 16;
    localparam int CW     = 2;
    localparam int FW     = 4;

    localparam logic [1:0] HEAD_STOP = 2'd0;
    localparam logic [1:0] HEAD_UP   = 2'd1;
    localparam logic [1:0] HEAD_DN   = 2'd2;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_HALL  = 2'd1;
    localparam logic [1:0] KIND_CAR   = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_SCAN,
        S_YIELD,
        S_MOVE,
        S_EMIT
    } t_state;
endpackage

### src/egd_if.sv
`timescale 1ns / 1ps
interface egd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [3:0] call_floor;
    logic       call_dir;
    logic [1:0] call_car;
    modport source (output valid, kind, call_floor, call_dir, call_car, input ready);
    modport sink   (input valid, kind, call_floor, call_dir, call_car, output ready);
endinterface

interface egd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  car_index;
    logic [3:0]  car_floor_now;
    logic [1:0]  car_heading;
    logic [3:0]  loading_left;
    logic [3:0]  unloading_left;
    logic [15:0] dest_bits;
    logic [15:0] hall_up_bits;
    logic [15:0] hall_down_bits;
    logic        last_car;
    modport source (output valid, car_index, car_floor_now, car_heading, loading_left,
                    unloading_left, dest_bits, hall_up_bits, hall_down_bits, last_car,
                    input ready);
    modport sink   (input valid, car_index, car_floor_now, car_heading, loading_left,
                    unloading_left, dest_bits, hall_up_bits, hall_down_bits, last_car,
                    output ready);
endinterface

interface egd_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### src/elevator_group_dispatcher.sv
`timescale 1ns / 1ps
// Elevator group dispatcher.
// s_in carries one word per event: a tick, a hall call or a car call.
// s_cfg writes dwell_ticks (reset 3); write it only while the block is idle.
// m_out returns one status word per car, car 0 first, last_car on the final one.
// A call is recorded on acceptance; the block then enters the emit state and sets
// the output valid register for the first status word. A tick runs car by car
// through one shared floor scanner: per car a timer step and, unless the car serves
// its own floor, a scan of the floors above and then below it plus a yield check
// against each other car when no destination settles the heading; then a move step per car.
// The four status words follow one per cycle while the receiver keeps ready high.
// The block takes one event at a time; s_in.ready is low from acceptance
// until the last status word has been taken.
// Status words are read from the live car registers, picked by a registered car
// index; when the receiver stalls the word holds and the block waits.
// Reset (synchronous, active low) clears all cars to floor 0, stopped, with
// no timers, destinations or hall calls.
module elevator_group_dispatcher (
    input  logic          i_clk,
    input  logic          i_rst_n,
    egd_in_if.sink        s_in,
    egd_cfg_if.sink       s_cfg,
    egd_out_if.source     m_out
);
    localparam int CW = egd_pkg::CW;
    localparam int FW = egd_pkg::FW;
    localparam int NC = egd_pkg::CARS;
    localparam int NF = egd_pkg::FLOORS;
    localparam logic [FW-1:0] TOP = FW'(NF - 1);

    egd_pkg::t_state r_state, n_state;

    logic [FW-1:0] r_pos   [NC];
    logic [1:0]    r_mot   [NC];
    logic [3:0]    r_load  [NC];
    logic [3:0]    r_unld  [NC];
    logic [NF-1:0] r_dest  [NC];
    logic [NF-1:0] r_hup, r_hdn;
    logic [3:0]    r_dwell;

    logic [CW-1:0] r_car;     // car being worked on
    logic [CW-1:0] r_k;       // other car under test
    logic [FW:0]   r_f;       // floor scan index (with a sign/overflow bit)
    logic          r_pass;    // 0 upward scan, 1 downward scan
    logic          r_dst_up, r_dst_dn, r_req_up, r_req_dn;
    logic [FW-1:0] r_near_hi, r_near_lo;
    logic          r_btw_up, r_btw_dn, r_opp_up, r_opp_dn;
    logic [1:0]    r_dir;
    logic          r_oval;
    logic [CW-1:0] r_ocar;

    logic acc_in;
    assign acc_in = s_in.valid && s_in.ready;
    assign s_in.ready  = (r_state == egd_pkg::S_IDLE);
    assign s_cfg.ready = 1'b1;

    logic yield_last, out_take;
    logic [FW-1:0] fl;
    assign fl = r_f[FW-1:0];
    assign out_take = r_oval && m_out.ready;
    assign yield_last = (r_k == CW'(NC - 1));

    // current car views
    logic [FW-1:0] cur;
    logic [NF-1:0] dm;
    assign cur = r_pos[r_car];
    assign dm  = r_dest[r_car];

    // tick-entry decision: timers, edge clamp and serving own floor
    logic [3:0] ld_dec, ul_dec, t_load, t_unld;
    logic [1:0] dir0, t_mot;
    logic       tick_decided;
    always_comb begin
        ld_dec = (r_load[r_car] != 4'd0) ? r_load[r_car] - 4'd1 : 4'd0;
        ul_dec = (r_unld[r_car] != 4'd0) ? r_unld[r_car] - 4'd1 : 4'd0;
        dir0 = r_mot[r_car];
        if ((cur == TOP && dir0 == egd_pkg::HEAD_UP) ||
            (cur == '0 && dir0 == egd_pkg::HEAD_DN))
            dir0 = egd_pkg::HEAD_STOP;
        t_load = ld_dec;
        t_unld = ul_dec;
        t_mot  = dir0;
        tick_decided = 1'b1;
        if (dm[cur]) begin
            if (ul_dec == 4'd0) t_unld = r_dwell;
        end else if (r_hup[cur] && dir0 != egd_pkg::HEAD_DN) begin
            t_mot = egd_pkg::HEAD_UP;
            if (ld_dec == 4'd0) t_load = r_dwell;
        end else if (r_hdn[cur] && dir0 != egd_pkg::HEAD_UP) begin
            t_mot = egd_pkg::HEAD_DN;
            if (ld_dec == 4'd0) t_load = r_dwell;
        end else begin
            tick_decided = 1'b0;
        end
    end

    // end-of-scan decision
    logic [1:0] scan_dir;
    egd_pkg::t_state scan_to;
    always_comb begin
        scan_to  = egd_pkg::S_YIELD;
        scan_dir = r_dir;
        if (!r_dst_up && !r_req_up && !r_dst_dn && !r_req_dn) begin
            scan_dir = egd_pkg::HEAD_STOP;
            scan_to  = egd_pkg::S_TICK;
        end else if (r_dst_up && r_dir != egd_pkg::HEAD_DN) begin
            scan_dir = egd_pkg::HEAD_UP;
            scan_to  = egd_pkg::S_TICK;
        end else if (r_dst_dn && r_dir != egd_pkg::HEAD_UP) begin
            scan_dir = egd_pkg::HEAD_DN;
            scan_to  = egd_pkg::S_TICK;
        end
        if (scan_to == egd_pkg::S_TICK && r_car == CW'(NC - 1))
            scan_to = egd_pkg::S_MOVE;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            egd_pkg::S_IDLE: begin
                if (acc_in)
                    n_state = (s_in.kind == egd_pkg::KIND_TICK) ? egd_pkg::S_TICK
                                                                 : egd_pkg::S_EMIT;
            end
            egd_pkg::S_TICK:  n_state = egd_pkg::S_TICK;
            egd_pkg::S_SCAN:  n_state = egd_pkg::S_SCAN;
            egd_pkg::S_YIELD: n_state = egd_pkg::S_YIELD;
            egd_pkg::S_MOVE:  n_state = egd_pkg::S_MOVE;
            egd_pkg::S_EMIT:  n_state = egd_pkg::S_EMIT;
            default:          n_state = egd_pkg::S_IDLE;
        endcase
        // transitions that depend on datapath outcomes
        if (r_state == egd_pkg::S_TICK && tick_decided)
            n_state = (r_car == CW'(NC - 1)) ? egd_pkg::S_MOVE : egd_pkg::S_TICK;
        else if (r_state == egd_pkg::S_TICK)
            n_state = egd_pkg::S_SCAN;
        if (r_state == egd_pkg::S_SCAN && r_pass && r_f[FW])
            n_state = scan_to;
        if (r_state == egd_pkg::S_YIELD && yield_last)
            n_state = (r_car == CW'(NC - 1)) ? egd_pkg::S_MOVE : egd_pkg::S_TICK;
        if (r_state == egd_pkg::S_MOVE && r_car == CW'(NC - 1))
            n_state = egd_pkg::S_EMIT;
        if (r_state == egd_pkg::S_EMIT && out_take && r_ocar == CW'(NC - 1))
            n_state = egd_pkg::S_IDLE;
    end

    // yield check on one other car
    logic [FW-1:0] of;
    logic [1:0]    od;
    logic          gu, gd, y_bu, y_bd, y_ou, y_od;
    logic [1:0]    fin_dir;
    always_comb begin
        of = r_pos[r_k];
        od = r_mot[r_k];
        gu = (od == egd_pkg::HEAD_UP) || (od == egd_pkg::HEAD_STOP);
        gd = (od == egd_pkg::HEAD_DN) || (od == egd_pkg::HEAD_STOP);
        y_bu = 1'b0; y_bd = 1'b0; y_ou = 1'b0; y_od = 1'b0;
        if (r_k != r_car) begin
            y_bu = gu && r_req_up && ((of > cur && of <= r_near_hi) ||
                                      (of == cur && r_k < r_car));
            y_bd = gd && r_req_dn && ((of < cur && of >= r_near_lo) ||
                                      (of == cur && r_k < r_car));
            y_ou = gu && r_req_dn && r_near_lo >= of &&
                   ({1'b0, r_near_lo - of} < {1'b0, cur - r_near_lo});
            y_od = gd && r_req_up && of >= r_near_hi &&
                   ({1'b0, of - r_near_hi} < {1'b0, r_near_hi - cur});
        end
        y_bu = y_bu || r_btw_up; y_bd = y_bd || r_btw_dn;
        y_ou = y_ou || r_opp_up; y_od = y_od || r_opp_dn;
        if (r_dir != egd_pkg::HEAD_DN && r_req_up && !y_bu && !y_od)
            fin_dir = egd_pkg::HEAD_UP;
        else if (r_dir != egd_pkg::HEAD_UP && r_req_dn && !y_bd && !y_ou)
            fin_dir = egd_pkg::HEAD_DN;
        else
            fin_dir = egd_pkg::HEAD_STOP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= egd_pkg::S_IDLE;
            r_hup   <= '0;
            r_hdn   <= '0;
            r_dwell <= 4'd3;
            r_oval  <= 1'b0;
            r_ocar  <= '0;
            r_car   <= '0;
            for (int c = 0; c < NC; c++) begin
                r_pos[c]  <= '0;
                r_mot[c]  <= egd_pkg::HEAD_STOP;
                r_load[c] <= '0;
                r_unld[c] <= '0;
                r_dest[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (s_cfg.valid)
                r_dwell <= s_cfg.data;
            unique case (r_state)
                egd_pkg::S_IDLE: begin
                    r_car <= '0;
                    if (acc_in) begin
                        if (s_in.kind == egd_pkg::KIND_HALL) begin
                            if (s_in.call_dir) r_hdn[s_in.call_floor] <= 1'b1;
                            else               r_hup[s_in.call_floor] <= 1'b1;
                        end else if (s_in.kind == egd_pkg::KIND_CAR &&
                                     s_in.call_floor != r_pos[s_in.call_car]) begin
                            if (r_mot[s_in.call_car] == egd_pkg::HEAD_STOP)
                                r_mot[s_in.call_car] <=
                                    (s_in.call_floor < r_pos[s_in.call_car]) ?
                                    egd_pkg::HEAD_DN : egd_pkg::HEAD_UP;
                            r_dest[s_in.call_car][s_in.call_floor] <= 1'b1;
                        end
                    end
                end
                // timers, clamp, serve own floor; else start the scan
                egd_pkg::S_TICK: begin
                    r_load[r_car] <= t_load;
                    r_unld[r_car] <= t_unld;
                    r_mot[r_car]  <= t_mot;
                    r_dir <= dir0;
                    r_dst_up <= 1'b0; r_dst_dn <= 1'b0;
                    r_req_up <= 1'b0; r_req_dn <= 1'b0;
                    r_near_hi <= '0; r_near_lo <= '0;
                    r_btw_up <= 1'b0; r_btw_dn <= 1'b0;
                    r_opp_up <= 1'b0; r_opp_dn <= 1'b0;
                    r_pass <= 1'b0;
                    r_f    <= {1'b0, cur} + (FW+1)'(1);
                    r_k    <= '0;
                    if (dm[cur])
                        r_dest[r_car][cur] <= 1'b0;
                    else if (r_hup[cur] && dir0 != egd_pkg::HEAD_DN)
                        r_hup[cur] <= 1'b0;
                    else if (r_hdn[cur] && dir0 != egd_pkg::HEAD_UP)
                        r_hdn[cur] <= 1'b0;
                    if (tick_decided)
                        r_car <= (r_car == CW'(NC - 1)) ? '0 : r_car + CW'(1);
                end
                // one floor per cycle: up pass then down pass
                egd_pkg::S_SCAN: begin
                    if (!r_pass) begin
                        if (r_f == (FW+1)'(NF)) begin
                            r_pass <= 1'b1;
                            r_f    <= {1'b0, cur} - (FW+1)'(1);
                        end else begin
                            if (dm[fl]) r_dst_up <= 1'b1;
                            if (r_hup[fl] || r_hdn[fl]) begin
                                if (!r_req_up) r_near_hi <= fl;
                                r_req_up <= 1'b1;
                            end
                            r_f <= r_f + (FW+1)'(1);
                        end
                    end else if (!r_f[FW]) begin
                        if (dm[fl]) r_dst_dn <= 1'b1;
                        if (r_hup[fl] || r_hdn[fl]) begin
                            if (!r_req_dn) r_near_lo <= fl;
                            r_req_dn <= 1'b1;
                        end
                        r_f <= r_f - (FW+1)'(1);
                    end else if (scan_to != egd_pkg::S_YIELD) begin
                        r_mot[r_car] <= scan_dir;
                        r_car <= (r_car == CW'(NC - 1)) ? '0 : r_car + CW'(1);
                    end
                end
                // one other car per cycle
                egd_pkg::S_YIELD: begin
                    r_btw_up <= y_bu; r_btw_dn <= y_bd;
                    r_opp_up <= y_ou; r_opp_dn <= y_od;
                    r_k <= r_k + CW'(1);
                    if (yield_last) begin
                        r_mot[r_car] <= fin_dir;
                        r_car <= (r_car == CW'(NC - 1)) ? '0 : r_car + CW'(1);
                    end
                end
                egd_pkg::S_MOVE: begin
                    if (r_load[r_car] == 4'd0 && r_unld[r_car] == 4'd0) begin
                        if (r_mot[r_car] == egd_pkg::HEAD_UP && r_pos[r_car] != TOP)
                            r_pos[r_car] <= r_pos[r_car] + FW'(1);
                        else if (r_mot[r_car] == egd_pkg::HEAD_DN && r_pos[r_car] != '0)
                            r_pos[r_car] <= r_pos[r_car] - FW'(1);
                    end
                    r_car <= r_car + CW'(1);
                end
                egd_pkg::S_EMIT: begin
                    if (!r_oval) begin
                        r_oval <= 1'b1;
                        r_ocar <= '0;
                    end else if (m_out.ready) begin
                        if (r_ocar == CW'(NC - 1)) r_oval <= 1'b0;
                        r_ocar <= r_ocar + CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // status word from live state
    assign m_out.valid          = r_oval;
    assign m_out.car_index      = r_ocar;
    assign m_out.car_floor_now  = r_pos[r_ocar];
    assign m_out.car_heading    = r_mot[r_ocar];
    assign m_out.loading_left   = r_load[r_ocar];
    assign m_out.unloading_left = r_unld[r_ocar];
    assign m_out.dest_bits      = r_dest[r_ocar];
    assign m_out.hall_up_bits   = r_hup;
    assign m_out.hall_down_bits = r_hdn;
    assign m_out.last_car       = (r_ocar == CW'(NC - 1));

    // checks
    a_out_only_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval |-> r_state == egd_pkg::S_EMIT) else $error("word outside emit");
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval |-> !s_in.ready) else $error("input taken while emitting");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oval && m_out.ready && m_out.last_car) |=> r_state == egd_pkg::S_IDLE)
        else $error("no return to idle");
endmodule
